// ===== hw/rtl/sfr_pkg.sv =====
// Package for the serial frame receiver: parser phases, register indexes,
// result record type and the CRC-16 byte update. No dependencies.

package sfr_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    // Configuration register indexes
    localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [2:0] REG_LENGTH_LIMIT  = 3'd2;
    localparam logic [2:0] REG_CRC_ENABLE    = 3'd3;
    localparam logic [2:0] REG_READ_OPCODE   = 3'd4;
    localparam logic [2:0] REG_WRITE_OPCODE  = 3'd5;
    localparam logic [2:0] REG_ACK_FIRST     = 3'd6;
    localparam logic [2:0] REG_ACK_SECOND    = 3'd7;

    // Frame kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Frame status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_CRC  = 2'd1;
    localparam logic [1:0] STAT_SIZE = 2'd2;

    // CRC-16, reflected polynomial
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // One result transaction
    typedef struct packed {
        logic [7:0]  body_byte;
        logic [7:0]  body_index;
        logic        is_payload;
        logic        frame_end;
        logic [1:0]  frame_kind;
        logic [1:0]  frame_status;
        logic [15:0] var_address;
        logic [7:0]  word_count;
        logic        ack_good;
    } result_t;

    // Fold one byte into the CRC, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/serial_frame_receiver_crc16_core.sv =====
// Serial frame receiver: header hunt, length check, body classification and
// optional CRC-16 check. Depends on sfr_pkg.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+-------------------------------
//   s_        | in        | s_valid / s_ready    | s_rx_byte
//   m_        | out       | m_valid / m_ready    | one body byte and frame report
//   cfg_      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle while s_ready is high: each accepted byte updates the
// parser state and, for body bytes, loads a result into the output register,
// or into the skid register when the output register stays full.
// A two-entry output stage (output register plus skid register) keeps s_ready
// high while one result waits; s_ready drops only when both are full. Reset is
// synchronous, active low, and restores the register defaults and hunting phase.

module serial_frame_receiver_crc16_core (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_body_byte,
    output logic [7:0]  m_body_index,
    output logic        m_is_payload,
    output logic        m_frame_end,
    output logic [1:0]  m_frame_kind,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_var_address,
    output logic [7:0]  m_word_count,
    output logic        m_ack_good,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import sfr_pkg::*;

    // Configuration registers
    logic [7:0] header_first_reg, header_second_reg, length_limit_reg;
    logic       crc_enable_reg;
    logic [7:0] read_opcode_reg, write_opcode_reg, ack_first_reg, ack_second_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  body_length_reg, body_length_next;
    logic [7:0]  bytes_seen_reg, bytes_seen_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  opcode_seen_reg, opcode_seen_next;
    logic [15:0] address_seen_reg, address_seen_next;
    logic [7:0]  count_seen_reg, count_seen_next;
    logic [7:0]  crc_low_seen_reg, crc_low_seen_next;
    logic [1:0]  ack_match_reg, ack_match_next;

    // Output stage
    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;
    logic    res_valid;

    logic s_fire, m_fire, len_ok, last_byte;
    logic [8:0] idx_ext, len_ext, crcsz_ext;
    logic [9:0] read_size;
    logic [15:0] rx_crc;
    logic [1:0]  kind;

    assign s_ready   = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = out_valid_reg && m_ready;

    // Configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= 8'h5A;
            header_second_reg <= 8'hA5;
            length_limit_reg  <= 8'd249;
            crc_enable_reg    <= 1'b0;
            read_opcode_reg   <= 8'h83;
            write_opcode_reg  <= 8'h82;
            ack_first_reg     <= 8'h4F;
            ack_second_reg    <= 8'h4B;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                REG_HEADER_SECOND: header_second_reg <= cfg_data;
                REG_LENGTH_LIMIT:  length_limit_reg  <= cfg_data;
                REG_CRC_ENABLE:    crc_enable_reg    <= cfg_data[0];
                REG_READ_OPCODE:   read_opcode_reg   <= cfg_data;
                REG_WRITE_OPCODE:  write_opcode_reg  <= cfg_data;
                REG_ACK_FIRST:     ack_first_reg     <= cfg_data;
                REG_ACK_SECOND:    ack_second_reg    <= cfg_data;
            endcase
        end
    end

    // Shared decode of the incoming byte
    assign len_ok    = (s_rx_byte != 8'd0) && (s_rx_byte <= length_limit_reg);
    assign idx_ext   = {1'b0, bytes_seen_reg};
    assign len_ext   = {1'b0, body_length_reg};
    assign crcsz_ext = crc_enable_reg ? 9'd2 : 9'd0;
    assign last_byte = (idx_ext + 9'd1) >= len_ext;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT1: begin
                phase_next = (s_rx_byte == header_first_reg) ? PH_HUNT2 : PH_HUNT1;
            end
            PH_HUNT2: begin
                priority if (s_rx_byte == header_second_reg) phase_next = PH_LEN;
                else if (s_rx_byte == header_first_reg)      phase_next = PH_HUNT2;
                else                                         phase_next = PH_HUNT1;
            end
            PH_LEN: begin
                // bad length: slide the header window by one byte
                priority if (len_ok) phase_next = PH_BODY;
                else if (header_second_reg == header_first_reg &&
                         s_rx_byte == header_second_reg) phase_next = PH_LEN;
                else if (s_rx_byte == header_first_reg)  phase_next = PH_HUNT2;
                else                                     phase_next = PH_HUNT1;
            end
            PH_BODY: begin
                phase_next = last_byte ? PH_HUNT1 : PH_BODY;
            end
            default: phase_next = PH_HUNT1;
        endcase
    end

    // Body datapath and result record
    always_comb begin
        body_length_next  = body_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_crc_next  = running_crc_reg;
        opcode_seen_next  = opcode_seen_reg;
        address_seen_next = address_seen_reg;
        count_seen_next   = count_seen_reg;
        crc_low_seen_next = crc_low_seen_reg;
        ack_match_next    = ack_match_reg;
        res_next          = '0;
        res_valid         = 1'b0;
        kind              = KIND_OTHER;
        rx_crc            = {s_rx_byte, crc_low_seen_reg};
        read_size         = 10'd4 + {1'b0, count_seen_reg, 1'b0} + {1'b0, crcsz_ext};

        if (phase_reg == PH_LEN && len_ok) begin
            body_length_next  = s_rx_byte;
            bytes_seen_next   = 8'd0;
            running_crc_next  = CRC_INIT;
            opcode_seen_next  = 8'd0;
            address_seen_next = 16'd0;
            count_seen_next   = 8'd0;
            crc_low_seen_next = 8'd0;
            ack_match_next    = 2'b00;
        end

        if (phase_reg == PH_BODY) begin
            // capture header fields of the body
            unique case (bytes_seen_reg)
                8'd0: opcode_seen_next = s_rx_byte;
                8'd1: begin
                    address_seen_next[15:8] = s_rx_byte;
                    if (s_rx_byte == ack_first_reg) ack_match_next[0] = 1'b1;
                end
                8'd2: begin
                    address_seen_next[7:0] = s_rx_byte;
                    if (s_rx_byte == ack_second_reg) ack_match_next[1] = 1'b1;
                end
                8'd3:    count_seen_next = s_rx_byte;
                default: ;
            endcase
            read_size = 10'd4 + {1'b0, count_seen_next, 1'b0} + {1'b0, crcsz_ext};

            priority if (opcode_seen_next == read_opcode_reg) kind = KIND_READ;
            else if (opcode_seen_next == write_opcode_reg)
                kind = (len_ext == 9'd3 + crcsz_ext) ? KIND_ACK : KIND_WRITE;
            else kind = KIND_OTHER;

            res_valid           = 1'b1;
            res_next.body_byte  = s_rx_byte;
            res_next.body_index = bytes_seen_reg;
            res_next.is_payload =
                ((kind == KIND_READ && idx_ext >= 9'd4) ||
                 (kind == KIND_WRITE && idx_ext >= 9'd3)) &&
                ((idx_ext + crcsz_ext) < len_ext);

            if (!last_byte) begin
                if ((idx_ext + 9'd2) < len_ext) begin
                    running_crc_next = crc16_byte(running_crc_reg, s_rx_byte);
                end else begin
                    crc_low_seen_next = s_rx_byte;
                end
                bytes_seen_next = bytes_seen_reg + 8'd1;
            end else begin
                // frame report on the last byte
                res_next.frame_end    = 1'b1;
                res_next.frame_kind   = kind;
                res_next.frame_status = STAT_OK;
                if (crc_enable_reg &&
                    (len_ext < 9'd3 || rx_crc != running_crc_reg)) begin
                    res_next.frame_status = STAT_CRC;
                end else if (kind == KIND_READ) begin
                    if (len_ext < 9'd4 || {1'b0, len_ext} != read_size)
                        res_next.frame_status = STAT_SIZE;
                end else if (kind == KIND_WRITE) begin
                    if (len_ext < 9'd4 || len_ext < 9'd3 + crcsz_ext)
                        res_next.frame_status = STAT_SIZE;
                end
                res_next.var_address = address_seen_next;
                res_next.word_count  = (kind == KIND_READ) ? count_seen_next : 8'd0;
                res_next.ack_good    = (kind == KIND_ACK) && (ack_match_next == 2'b11);
                bytes_seen_next      = 8'd0;
            end
        end
    end

    // Parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT1;
            body_length_reg  <= 8'd0;
            bytes_seen_reg   <= 8'd0;
            running_crc_reg  <= CRC_INIT;
            opcode_seen_reg  <= 8'd0;
            address_seen_reg <= 16'd0;
            count_seen_reg   <= 8'd0;
            crc_low_seen_reg <= 8'd0;
            ack_match_reg    <= 2'b00;
        end else if (s_fire) begin
            phase_reg        <= phase_next;
            body_length_reg  <= body_length_next;
            bytes_seen_reg   <= bytes_seen_next;
            running_crc_reg  <= running_crc_next;
            opcode_seen_reg  <= opcode_seen_next;
            address_seen_reg <= address_seen_next;
            count_seen_reg   <= count_seen_next;
            crc_low_seen_reg <= crc_low_seen_next;
            ack_match_reg    <= ack_match_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_fire && res_valid) begin
            if (!out_valid_reg || m_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) out_reg <= skid_reg;
        end else if (s_fire && res_valid) begin
            if (!out_valid_reg || m_fire) out_reg  <= res_next;
            else                          skid_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_body_byte    = out_reg.body_byte;
    assign m_body_index   = out_reg.body_index;
    assign m_is_payload   = out_reg.is_payload;
    assign m_frame_end    = out_reg.frame_end;
    assign m_frame_kind   = out_reg.frame_kind;
    assign m_frame_status = out_reg.frame_status;
    assign m_var_address  = out_reg.var_address;
    assign m_word_count   = out_reg.word_count;
    assign m_ack_good     = out_reg.ack_good;

`ifndef SYNTHESIS
    // skid entry is only ever filled behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a waiting skid entry moves up when the output is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not forwarded");

    // frame report fields stay zero before the last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_end) |->
            (m_frame_kind == KIND_READ && m_frame_status == STAT_OK &&
             m_var_address == 16'd0 && m_word_count == 8'd0 && !m_ack_good))
        else $error("frame report set on a non-final byte");

    // in the body phase the byte index stays below the frame length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (bytes_seen_reg < body_length_reg))
        else $error("body index beyond frame length");
`endif

endmodule
